/* sv/u16u8_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file refers to this package by scoped names.
package u16u8_pkg;

    // Values of the func field
    localparam logic FUNC_FEED  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam int UNIT_W   = 16;
    localparam int CP_W     = 21;
    localparam int SURR_W   = 10;
    localparam int BYTE_W   = 8;
    localparam int MAX_BYTES = 4;
    localparam int IDX_W    = $clog2(MAX_BYTES);

    // Top six bits of a surrogate code unit
    localparam logic [5:0] HIGH_TAG = 6'b110110;  // 0xD800 to 0xDBFF
    localparam logic [5:0] LOW_TAG  = 6'b110111;  // 0xDC00 to 0xDFFF

    // 0x10000 >> 10, added to the high surrogate field
    localparam logic [CP_W-SURR_W-1:0] SUPP_BASE = 11'd64;

    // Entries in the queue between the front and back parts
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One encoded character: its bytes, first in element 0, and the index of the last
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } char_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* sv/u16u8_in_if.sv */
// Input channel of the transcoder: one UTF-16 code unit or a clear request per item.
// Depends on u16u8_pkg for the field widths.
interface u16u8_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [u16u8_pkg::UNIT_W-1:0]  code_unit;

    modport source (output valid, output func, output code_unit, input ready);
    modport sink   (input valid, input func, input code_unit, output ready);
endinterface

/* sv/u16u8_out_if.sv */
// Output channel of the transcoder: one UTF-8 byte per item, last byte marked.
// Depends on u16u8_pkg for the field widths.
interface u16u8_out_if;
    logic                          valid;
    logic                          ready;
    logic [u16u8_pkg::BYTE_W-1:0]  out_byte;
    logic                          last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

/* sv/u16u8_front.sv */
// Front part: accepts code units, tracks the pending high surrogate and
// encodes each complete character into a queue entry. Depends on u16u8_pkg, u16u8_in_if.
module u16u8_front (
    input  logic                    clk,
    input  logic                    rst_n,
    u16u8_in_if.sink                din,
    input  u16u8_pkg::q_stat_t      q_stat,
    output logic                    push,
    output u16u8_pkg::char_t        push_data
);

    logic                               pend_valid_reg, pend_valid_next;
    logic [u16u8_pkg::SURR_W-1:0]       pend_bits_reg, pend_bits_next;
    logic                               accept;
    logic                               is_high;
    logic                               is_low;
    logic [u16u8_pkg::CP_W-1:0]         cp;

    assign din.ready = !q_stat.full;
    assign accept    = din.valid && din.ready;
    assign is_high   = din.code_unit[15:10] == u16u8_pkg::HIGH_TAG;
    assign is_low    = din.code_unit[15:10] == u16u8_pkg::LOW_TAG;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        push            = 1'b0;
        if (accept)
        begin
            if (din.func == u16u8_pkg::FUNC_CLEAR)
            begin
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
            end
            else if (is_high)
            begin
                pend_valid_next = 1'b1;
                pend_bits_next  = din.code_unit[u16u8_pkg::SURR_W-1:0];
            end
            else
            begin
                // lone low surrogate leaves state as it is (already clear)
                push            = !is_low || pend_valid_reg;
                pend_valid_next = 1'b0;
                pend_bits_next  = '0;
            end
        end
    end

    // Code point: surrogate pair or the unit itself
    always_comb
    begin
        if (is_low)
            cp = {{1'b0, pend_bits_reg} + u16u8_pkg::SUPP_BASE,
                  din.code_unit[u16u8_pkg::SURR_W-1:0]};
        else
            cp = {{(u16u8_pkg::CP_W-u16u8_pkg::UNIT_W){1'b0}}, din.code_unit};
    end

    always_comb
    begin
        push_data.bytes = '0;
        if (cp[20:7] == '0)
        begin
            push_data.bytes[0] = {1'b0, cp[6:0]};
            push_data.last_idx = 2'd0;
        end
        else if (cp[20:11] == '0)
        begin
            push_data.bytes[0] = {3'b110, cp[10:6]};
            push_data.bytes[1] = {2'b10, cp[5:0]};
            push_data.last_idx = 2'd1;
        end
        else if (cp[20:16] == '0)
        begin
            push_data.bytes[0] = {4'b1110, cp[15:12]};
            push_data.bytes[1] = {2'b10, cp[11:6]};
            push_data.bytes[2] = {2'b10, cp[5:0]};
            push_data.last_idx = 2'd2;
        end
        else
        begin
            push_data.bytes[0] = {5'b11110, cp[20:18]};
            push_data.bytes[1] = {2'b10, cp[17:12]};
            push_data.bytes[2] = {2'b10, cp[11:6]};
            push_data.bytes[3] = {2'b10, cp[5:0]};
            push_data.last_idx = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

endmodule

/* sv/u16u8_queue.sv */
// Short queue of encoded characters between the front and back parts.
// Depends on u16u8_pkg.
module u16u8_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  u16u8_pkg::char_t        push_data,
    input  logic                    pop,
    output u16u8_pkg::char_t        head,
    output u16u8_pkg::q_stat_t      q_stat
);

    u16u8_pkg::char_t                   entry_reg [u16u8_pkg::QDEPTH];
    logic [u16u8_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [u16u8_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [u16u8_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                               do_push;
    logic                               do_pop;

    assign q_stat.full  = cnt_reg == u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == u16u8_pkg::QPTR_W'(u16u8_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* sv/u16u8_back.sv */
// Back part: takes encoded characters from the queue and sends them out one
// byte per item through an output register. Depends on u16u8_pkg, u16u8_out_if.
module u16u8_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  u16u8_pkg::char_t        head,
    input  u16u8_pkg::q_stat_t      q_stat,
    output logic                    pop,
    u16u8_out_if.source             dout
);

    logic                               have_reg, have_next;
    u16u8_pkg::char_t                   cur_reg, cur_next;
    logic [u16u8_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                               ov_reg, ov_next;
    logic [u16u8_pkg::BYTE_W-1:0]       ob_reg, ob_next;
    logic                               ol_reg, ol_next;
    logic                               load;

    assign load           = !ov_reg || dout.ready;
    assign dout.valid     = ov_reg;
    assign dout.out_byte  = ob_reg;
    assign dout.last_byte = ol_reg;

    always_comb
    begin
        have_next = have_reg;
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        pop       = 1'b0;
        if (load)
        begin
            if (have_reg)
            begin
                ov_next  = 1'b1;
                ob_next  = cur_reg.bytes[idx_reg];
                ol_next  = idx_reg == cur_reg.last_idx;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cur_reg.last_idx)
                    have_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                // first byte goes straight out, the rest stay in the holding register
                pop       = 1'b1;
                ov_next   = 1'b1;
                ob_next   = head.bytes[0];
                ol_next   = head.last_idx == '0;
                cur_next  = head;
                idx_next  = u16u8_pkg::IDX_W'(1);
                have_next = head.last_idx != '0;
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

/* sv/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder, top level.
// Depends on u16u8_pkg, u16u8_in_if, u16u8_out_if, u16u8_front, u16u8_queue, u16u8_back.
//
// Channels: din takes one item per code unit (func = feed) or a clear request
// (func = clear); dout gives one UTF-8 byte per item, last_byte set on the
// final byte of each character. Both use valid/ready; an item moves on a
// rising edge with valid and ready high.
// High surrogates and lone low surrogates give no bytes; a surrogate pair
// gives four bytes, any other unit one to three.
// A unit is written to the character queue at the edge that accepts it; its
// first byte moves from the queue head into the output register once the back
// is done with earlier characters and dout has taken any byte it holds.
// The output port moves one byte a cycle while characters are waiting and
// dout.ready stays high; a unit gives one to four bytes, four for a pair.
// din.ready falls only while the two-entry character queue is full, so the
// front keeps accepting while the back drains or dout is stalled, until the queue fills.
// When dout stalls, the presented byte holds until taken; nothing is lost.
// Reset clears the pending surrogate, empties the queue and drops dout.valid.
module utf16_to_utf8_transcoder (
    input  logic            clk,
    input  logic            rst_n,
    u16u8_in_if.sink        din,
    u16u8_out_if.source     dout
);

    u16u8_pkg::q_stat_t     q_stat;
    u16u8_pkg::char_t       push_data;
    u16u8_pkg::char_t       head;
    logic                   push;
    logic                   pop;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    u16u8_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    u16u8_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .dout   (dout)
    );

    // A character is never pushed into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // The back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // Queue cannot be full and empty at once
    a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // A pop that leaves the output idle would lose a byte
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> dout.valid)
        else $error("popped character not presented");

endmodule
